// ===== rtl/core/bpq_pkg.sv =====
// Shared types and constants for the bucketed priority queue.
// No dependencies; imported by bpq_cell and bucketed_priority_queue.
`timescale 1ns / 1ps
`default_nettype none

package bpq_pkg;

    localparam int NUM_LEVELS_DEF   = 8;
    localparam int LEVEL_DEPTH_DEF  = 16;
    localparam int PAYLOAD_BITS_DEF = 16;

    localparam int OUT_PAYLOAD_W = 16;
    localparam int OUT_LEVEL_W   = 3;
    localparam int OUT_TOTAL_W   = 8;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY_POP  = 2'd1,
        ST_LEVEL_FULL = 2'd2,
        ST_NULL_PUSH  = 2'd3
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_cmd_t;

    typedef struct packed {
        logic nonempty;
        logic full;
    } cell_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/bpq_cell.sv =====
// One priority level: FIFO of payload handles plus one stage of the top-item scan chain.
// Depends on bpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpq_cell #(
    parameter int CELL_LEVEL  = 0,
    parameter int NUM_LEVELS  = bpq_pkg::NUM_LEVELS_DEF,
    parameter int LEVEL_DEPTH = bpq_pkg::LEVEL_DEPTH_DEF,
    parameter int STORE_W     = bpq_pkg::PAYLOAD_BITS_DEF,
    parameter int LVL_W       = $clog2(NUM_LEVELS)
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire bpq_pkg::cell_cmd_t     cmd,
    input  wire         [STORE_W-1:0]   wr_data,
    input  wire                         chain_in_found,
    input  wire         [LVL_W-1:0]     chain_in_level,
    input  wire         [STORE_W-1:0]   chain_in_data,
    output logic                        chain_out_found,
    output logic        [LVL_W-1:0]     chain_out_level,
    output logic        [STORE_W-1:0]   chain_out_data,
    output bpq_pkg::cell_stat_t         stat
);
    import bpq_pkg::*;

    localparam int PTR_W  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int FILL_W = $clog2(LEVEL_DEPTH + 1);

    logic [STORE_W-1:0] mem [LEVEL_DEPTH];
    logic [STORE_W-1:0] rd_reg;

    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;

    logic               found_reg, found_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic [STORE_W-1:0] data_reg,  data_next;

    assign stat = '{nonempty: (fill_reg != '0),
                    full:     (fill_reg == FILL_W'(LEVEL_DEPTH))};

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (cmd.push)
        begin
            tail_next = (tail_reg == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            head_next = (head_reg == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end
    end

    // scan stage: a nonempty level overrides anything from the levels above it
    always_comb
    begin
        if (stat.nonempty)
        begin
            found_next = 1'b1;
            level_next = LVL_W'(CELL_LEVEL);
            data_next  = rd_reg;
        end
        else
        begin
            found_next = chain_in_found;
            level_next = chain_in_level;
            data_next  = chain_in_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[tail_reg] <= wr_data;
        end
        rd_reg <= mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
            found_reg <= 1'b0;
            level_reg <= '0;
            data_reg  <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
            found_reg <= found_next;
            level_reg <= level_next;
            data_reg  <= data_next;
        end
    end

    assign chain_out_found = found_reg;
    assign chain_out_level = level_reg;
    assign chain_out_data  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bucketed_priority_queue.sv =====
// Bucketed priority queue top level: sequencer, total count and a chain of level cells.
// Depends on bpq_pkg and bpq_cell.
//
// Usage:
//   Slave channel s_axis_*: one word per command (push, pop or peek) with the
//   priority level and payload handle. tuser carries the operation code.
//   Master channel m_axis_*: one word per command with the status in tuser and
//   the current top item, its level, the empty flag and the item count in tdata.
//   Each level cell holds its own FIFO; the top item is found by a registered
//   scan chain running from the highest level down to level 0.
//   Each accepted word passes the execute state, then waits in the settle state
//   for the FIFO head read and the scan chain to settle. s_axis_tready returns
//   in the cycle the result is loaded, so a new word is taken only after the
//   last one's result is loaded; the scan chain length sets the settle wait.
//   The next word is taken and executed while a result still waits in the output
//   register; only the load of its result waits for the receiver.
//   Reset clears all levels and counts; the queue starts empty and ready. A
//   stalled receiver holds m_axis_tdata and m_axis_tuser steady.
`timescale 1ns / 1ps
`default_nettype none

module bucketed_priority_queue #(
    parameter int NUM_LEVELS   = bpq_pkg::NUM_LEVELS_DEF,
    parameter int LEVEL_DEPTH  = bpq_pkg::LEVEL_DEPTH_DEF,
    parameter int PAYLOAD_BITS = bpq_pkg::PAYLOAD_BITS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // [2:0] item_priority, [18:3] item_payload, rest zero
    input  wire  [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] top_payload, [18:16] top_level,
                                        // [19] queue_empty, [27:20] total_entries
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import bpq_pkg::*;

    localparam int LVL_W   = $clog2(NUM_LEVELS);
    localparam int STORE_W = (PAYLOAD_BITS < OUT_PAYLOAD_W) ? PAYLOAD_BITS : OUT_PAYLOAD_W;
    localparam int TOT_W   = $clog2(NUM_LEVELS * LEVEL_DEPTH + 1);
    localparam int CNT_W   = $clog2(NUM_LEVELS + 2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SETTLE
    } state_t;

    state_t             state_reg;
    op_t                op_reg;
    logic [LVL_W-1:0]   lvl_reg;
    logic [STORE_W-1:0] pay_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [TOT_W-1:0]   total_reg;
    logic               out_valid_reg;
    status_t            out_status_reg;
    // status of the executing word is kept apart from the word still on the port
    status_t            pend_status_reg;
    status_t            exec_status;
    logic [31:0]        out_data_reg;

    cell_cmd_t          cmd   [NUM_LEVELS];
    cell_stat_t         stat  [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] full_vec;

    logic               chain_found [NUM_LEVELS+1];
    logic [LVL_W-1:0]   chain_level [NUM_LEVELS+1];
    logic [STORE_W-1:0] chain_data  [NUM_LEVELS+1];

    logic [2:0]         in_prio;
    logic [15:0]        in_payload;
    logic [LVL_W-1:0]   in_lvl_sat;

    logic               is_push, is_pop, null_push, lvl_full;
    logic               do_push, do_pop;
    logic               out_free;
    logic               load_now;
    logic [31:0]        result_data;

    assign in_prio    = s_axis_tdata[2:0];
    assign in_payload = s_axis_tdata[18:3];
    assign in_lvl_sat = (int'(in_prio) >= NUM_LEVELS) ? LVL_W'(NUM_LEVELS - 1)
                                                      : LVL_W'(in_prio);

    assign chain_found[NUM_LEVELS] = 1'b0;
    assign chain_level[NUM_LEVELS] = '0;
    assign chain_data[NUM_LEVELS]  = '0;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_LEVELS; gi++)
        begin : g_cell
            assign full_vec[gi] = stat[gi].full;
            assign cmd[gi]      = '{push: do_push && (lvl_reg == LVL_W'(gi)),
                                    pop:  do_pop && (chain_level[0] == LVL_W'(gi))};

            bpq_cell #(
                .CELL_LEVEL  (gi),
                .NUM_LEVELS  (NUM_LEVELS),
                .LEVEL_DEPTH (LEVEL_DEPTH),
                .STORE_W     (STORE_W),
                .LVL_W       (LVL_W)
            ) u_cell (
                .clk             (clk),
                .rst_n           (rst_n),
                .cmd             (cmd[gi]),
                .wr_data         (pay_reg),
                .chain_in_found  (chain_found[gi+1]),
                .chain_in_level  (chain_level[gi+1]),
                .chain_in_data   (chain_data[gi+1]),
                .chain_out_found (chain_found[gi]),
                .chain_out_level (chain_level[gi]),
                .chain_out_data  (chain_data[gi]),
                .stat            (stat[gi])
            );
        end
    endgenerate

    always_comb
    begin
        is_push = 1'b0;
        is_pop  = 1'b0;
        case (op_reg)
            OP_PUSH: is_push = 1'b1;
            OP_POP:  is_pop  = 1'b1;
            default: ;
        endcase
    end

    assign null_push = (pay_reg == '0);
    assign lvl_full  = full_vec[lvl_reg];
    assign do_push   = (state_reg == S_EXEC) && is_push && !null_push && !lvl_full;
    assign do_pop    = (state_reg == S_EXEC) && is_pop && chain_found[0];

    always_comb
    begin
        exec_status = ST_OK;
        if (is_push)
        begin
            if (null_push)
            begin
                exec_status = ST_NULL_PUSH;
            end
            else if (lvl_full)
            begin
                exec_status = ST_LEVEL_FULL;
            end
        end
        else if (is_pop && !chain_found[0])
        begin
            exec_status = ST_EMPTY_POP;
        end
    end

    assign result_data = {4'b0000,
                          OUT_TOTAL_W'(total_reg),
                          !chain_found[0],
                          OUT_LEVEL_W'(chain_level[0]),
                          OUT_PAYLOAD_W'(chain_data[0])};

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign load_now      = (state_reg == S_SETTLE) && (cnt_reg == '0) && out_free;
    assign s_axis_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_PEEK;
            lvl_reg         <= '0;
            pay_reg         <= '0;
            cnt_reg         <= '0;
            total_reg       <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_OK;
            pend_status_reg <= ST_OK;
            out_data_reg    <= '0;
        end
        else
        begin
            if (load_now)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        op_reg    <= op_t'(s_axis_tuser);
                        lvl_reg   <= in_lvl_sat;
                        pay_reg   <= STORE_W'(in_payload);
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    pend_status_reg <= exec_status;
                    if (do_push)
                    begin
                        total_reg <= total_reg + 1'b1;
                    end
                    else if (do_pop)
                    begin
                        total_reg <= total_reg - 1'b1;
                    end
                    cnt_reg   <= CNT_W'(NUM_LEVELS + 1);
                    state_reg <= S_SETTLE;
                end
                S_SETTLE:
                begin
                    if (cnt_reg != '0)
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                    else if (out_free)
                    begin
                        out_data_reg   <= result_data;
                        out_status_reg <= pend_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule

`default_nettype wire
